// File: hdl/rbfcs_pkg.sv
// ----------------------------------------------------------------------------
// rbfcs_pkg: shared definitions for the RBF colour similarity evaluator
// Sizes, register indexes, state types and the exp(-x) bit constants.
// ----------------------------------------------------------------------------
package rbfcs_pkg;

   localparam int MAX_BASIS = 64;
   localparam int CNT_W     = $clog2(MAX_BASIS + 1);
   localparam int SUM_W     = 32 + $clog2(MAX_BASIS + 1);

   localparam int D2_W      = 18;
   localparam int P_W       = 24 + D2_W;
   localparam int EXP_BITS  = 21;
   localparam int K_W       = 5;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_SIGMA = 2'd0;
   localparam logic [1:0] CSR_COUNT = 2'd1;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [23:0] color;
      logic [31:0] coef;
   } basis_type;

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_WAIT, S_SKIP, S_DONE
   } seq_state_type;

   typedef enum logic [2:0] {
      T_IDLE, T_SCALE, T_EXP, T_ROUND, T_MUL, T_DONE
   } term_state_type;

   // round(exp(-2^(k-16)) * 2^32) for each bit k of the Q.16 exponent.
   localparam logic [31:0] EXP_TAB [EXP_BITS] = '{
      32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
      32'd4293918848, 32'd4292870656, 32'd4290774639, 32'd4286586875,
      32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
      32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
      32'd1580030169, 32'd581260616,  32'd78665070,   32'd1440801,
      32'd483
   };

endpackage

// File: hdl/rbfcs_cell.sv
// ----------------------------------------------------------------------------
// rbfcs_cell: one basis entry of the rotating ring
// Holds a colour and weight; takes a direct write or its neighbour's entry.
// ----------------------------------------------------------------------------
module rbfcs_cell (
   input  logic                clock,
   input  logic                write_en,
   input  rbfcs_pkg::basis_type write_data,
   input  logic                shift_en,
   input  rbfcs_pkg::basis_type shift_data,
   output rbfcs_pkg::basis_type entry
);

   rbfcs_pkg::basis_type entry_ff;
   rbfcs_pkg::basis_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (write_en) begin
         entry_in = write_data;
      end else if (shift_en) begin
         entry_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: hdl/rbfcs_term.sv
// ----------------------------------------------------------------------------
// rbfcs_term: weighted Gaussian term for one basis entry
// Distance, scaling, bit-serial exp(-x) product, rounding and weighting.
// ----------------------------------------------------------------------------
module rbfcs_term (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [23:0]          pixel,
   input  rbfcs_pkg::basis_type basis,
   input  logic [23:0]          sigma,
   output logic                 done,
   output logic [31:0]          term
);

   rbfcs_pkg::term_state_type state_ff, state_in;

   logic [rbfcs_pkg::D2_W-1:0] d2_ff, d2_in;
   logic [31:0]                coef_ff, coef_in;
   logic [rbfcs_pkg::P_W-1:0]  p_ff, p_in;
   logic [32:0]                acc_ff, acc_in;
   logic [rbfcs_pkg::K_W-1:0]  k_ff, k_in;
   logic [15:0]                e_ff, e_in;
   logic [31:0]                term_ff, term_in;

   logic [7:0]  diff0, diff1, diff2;
   logic [rbfcs_pkg::D2_W-1:0] d2_now;
   logic [20:0] x_val;
   logic [64:0] prod;
   logic [32:0] rounded;
   logic [47:0] weighted;
   logic        too_far;

   always_comb begin
      diff0  = (pixel[7:0] > basis.color[7:0]) ? pixel[7:0] - basis.color[7:0]
                                                : basis.color[7:0] - pixel[7:0];
      diff1  = (pixel[15:8] > basis.color[15:8]) ? pixel[15:8] - basis.color[15:8]
                                                  : basis.color[15:8] - pixel[15:8];
      diff2  = (pixel[23:16] > basis.color[23:16])
               ? pixel[23:16] - basis.color[23:16] : basis.color[23:16] - pixel[23:16];
      d2_now = rbfcs_pkg::D2_W'(diff0 * diff0) + rbfcs_pkg::D2_W'(diff1 * diff1)
             + rbfcs_pkg::D2_W'(diff2 * diff2);
      too_far  = p_ff > rbfcs_pkg::P_W'(64'd1 << 28);
      x_val    = p_ff[28:8];
      prod     = 65'(acc_ff) * 65'(rbfcs_pkg::EXP_TAB[k_ff]);
      rounded  = acc_ff + 33'd32768;
      weighted = 48'(coef_ff) * 48'(e_ff);
   end

   always_comb begin
      state_in = state_ff;
      d2_in    = d2_ff;
      coef_in  = coef_ff;
      p_in     = p_ff;
      acc_in   = acc_ff;
      k_in     = k_ff;
      e_in     = e_ff;
      term_in  = term_ff;
      done     = 1'b0;
      unique case (state_ff)
         rbfcs_pkg::T_IDLE: begin
            if (start) begin
               d2_in    = d2_now;
               coef_in  = basis.coef;
               state_in = rbfcs_pkg::T_SCALE;
            end
         end
         rbfcs_pkg::T_SCALE: begin
            p_in     = rbfcs_pkg::P_W'(sigma) * rbfcs_pkg::P_W'(d2_ff);
            acc_in   = 33'd1 << 32;
            k_in     = '0;
            state_in = rbfcs_pkg::T_EXP;
         end
         rbfcs_pkg::T_EXP: begin
            // One constant factor per exponent bit, one bit a cycle.
            if (too_far) begin
               acc_in   = '0;
               state_in = rbfcs_pkg::T_ROUND;
            end else begin
               if (x_val[k_ff]) begin
                  acc_in = prod[64:32];
               end
               k_in = k_ff + 1'b1;
               if (k_ff == rbfcs_pkg::K_W'(rbfcs_pkg::EXP_BITS - 1)) begin
                  state_in = rbfcs_pkg::T_ROUND;
               end
            end
         end
         rbfcs_pkg::T_ROUND: begin
            e_in     = rounded[32] ? 16'hFFFF : rounded[31:16];
            state_in = rbfcs_pkg::T_MUL;
         end
         rbfcs_pkg::T_MUL: begin
            term_in  = weighted[47:16];
            state_in = rbfcs_pkg::T_DONE;
         end
         rbfcs_pkg::T_DONE: begin
            done     = 1'b1;
            state_in = rbfcs_pkg::T_IDLE;
         end
         default: state_in = rbfcs_pkg::T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbfcs_pkg::T_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      d2_ff   <= d2_in;
      coef_ff <= coef_in;
      p_ff    <= p_in;
      acc_ff  <= acc_in;
      k_ff    <= k_in;
      e_ff    <= e_in;
      term_ff <= term_in;
   end

   assign term = term_ff;

endmodule

// File: hdl/rbf_color_similarity_eval.sv
// ----------------------------------------------------------------------------
// rbf_color_similarity_eval: Gaussian RBF colour similarity evaluator
// Basis entries sit in a rotating ring of cells; one shared unit works out
// each weighted term as the ring brings the entries past it.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    kind, entry_index, colour, coef, last
//  rsp      out        rsp_valid/rsp_ready    similarity, last_out
//  csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A load item is written into its cell. A pixel item runs the term unit for each
// entry in use (the bit-serial exp product has 21 steps, cut short where the
// exponent passes 16), then turns the ring through each remaining position up
// to MAX_BASIS and hands over. Reset is synchronous; the basis store is not
// cleared. A result waits in the output register while the next item is accepted;
// a pixel that finishes while that register is still full holds in its last step.
// ----------------------------------------------------------------------------
module rbf_color_similarity_eval (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [5:0]  req_entry_index,
   input  logic [7:0]  req_color_c0,
   input  logic [7:0]  req_color_c1,
   input  logic [7:0]  req_color_c2,
   input  logic [31:0] req_coefficient,
   input  logic        req_last_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_similarity,
   output logic        rsp_last_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   rbfcs_pkg::seq_state_type state_ff, state_in;

   logic [23:0]               sigma_ff;
   logic [6:0]                count_ff;
   logic [23:0]               pix_ff, pix_in;
   logic                      last_ff, last_in;
   rbfcs_pkg::cnt_type        cnt_ff, cnt_in;
   logic [rbfcs_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_sim_ff, rsp_sim_in;
   logic                      rsp_last_ff, rsp_last_in;

   rbfcs_pkg::cnt_type        used;
   rbfcs_pkg::cnt_type        cnt_next;
   logic                      accept;
   logic                      load_item;
   logic                      rotate;
   logic                      term_start;
   logic                      term_done;
   logic [31:0]               term_val;
   rbfcs_pkg::basis_type      write_data;
   rbfcs_pkg::basis_type      ring [rbfcs_pkg::MAX_BASIS];

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == rbfcs_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_item = accept && !req_kind
                      && (32'(req_entry_index) < rbfcs_pkg::MAX_BASIS);
   assign write_data = '{color: {req_color_c2, req_color_c1, req_color_c0},
                         coef: req_coefficient};
   assign used = (32'(count_ff) > rbfcs_pkg::MAX_BASIS)
                 ? rbfcs_pkg::cnt_type'(rbfcs_pkg::MAX_BASIS)
                 : rbfcs_pkg::cnt_type'(count_ff);
   assign cnt_next = cnt_ff + 1'b1;

   // Cell i takes from cell i+1 (the last cell from cell 0); cell 0 feeds the term unit.
   for (genvar i = 0; i < rbfcs_pkg::MAX_BASIS; i++) begin : g_ring
      rbfcs_cell u_cell (
         .clock      (clock),
         .write_en   (load_item && (32'(req_entry_index) == i)),
         .write_data (write_data),
         .shift_en   (rotate),
         .shift_data (ring[(i + 1) % rbfcs_pkg::MAX_BASIS]),
         .entry      (ring[i])
      );
   end

   rbfcs_term u_term (
      .clock  (clock),
      .reset  (reset),
      .start  (term_start),
      .pixel  (pix_ff),
      .basis  (ring[0]),
      .sigma  (sigma_ff),
      .done   (term_done),
      .term   (term_val)
   );

   always_comb begin
      state_in     = state_ff;
      pix_in       = pix_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sim_in   = rsp_sim_ff;
      rsp_last_in  = rsp_last_ff;
      rotate       = 1'b0;
      term_start   = 1'b0;
      unique case (state_ff)
         rbfcs_pkg::S_IDLE: begin
            if (accept && req_kind) begin
               pix_in   = {req_color_c2, req_color_c1, req_color_c0};
               last_in  = req_last_pixel;
               cnt_in   = '0;
               sum_in   = '0;
               state_in = (used == '0) ? rbfcs_pkg::S_DONE : rbfcs_pkg::S_START;
            end
         end
         rbfcs_pkg::S_START: begin
            term_start = 1'b1;
            state_in   = rbfcs_pkg::S_WAIT;
         end
         rbfcs_pkg::S_WAIT: begin
            if (term_done) begin
               sum_in = sum_ff + rbfcs_pkg::SUM_W'(term_val);
               rotate = 1'b1;
               cnt_in = cnt_next;
               if (cnt_next < used) begin
                  state_in = rbfcs_pkg::S_START;
               end else if (cnt_next == rbfcs_pkg::cnt_type'(rbfcs_pkg::MAX_BASIS)) begin
                  state_in = rbfcs_pkg::S_DONE;
               end else begin
                  state_in = rbfcs_pkg::S_SKIP;
               end
            end
         end
         rbfcs_pkg::S_SKIP: begin
            // Turn the ring the rest of the way so slots line up for loads.
            rotate = 1'b1;
            cnt_in = cnt_next;
            if (cnt_next == rbfcs_pkg::cnt_type'(rbfcs_pkg::MAX_BASIS)) begin
               state_in = rbfcs_pkg::S_DONE;
            end
         end
         rbfcs_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sim_in   = (sum_ff[rbfcs_pkg::SUM_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                                  : sum_ff[31:0];
               rsp_last_in  = last_ff;
               state_in     = rbfcs_pkg::S_IDLE;
            end
         end
         default: state_in = rbfcs_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbfcs_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         sigma_ff     <= 24'd50332;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               rbfcs_pkg::CSR_SIGMA: sigma_ff <= csr_data;
               rbfcs_pkg::CSR_COUNT: count_ff <= csr_data[6:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      last_ff     <= last_in;
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
      rsp_sim_ff  <= rsp_sim_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_similarity = rsp_sim_ff;
   assign rsp_last_out   = rsp_last_ff;

endmodule
